### hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pip_pkg.sv
package pip_pkg;

    localparam int COORD_BITS   = 16;
    localparam int MAX_VERTICES = 64;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int VIDX_W       = 6;
    localparam int CNT_W        = 7;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int QUO_W        = DIFF_W + 1;
    localparam int VERT_W       = 2 * COORD_BITS;
    localparam int S_TDATA_W    = ((VIDX_W + 2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = 8;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = CNT_W'(3);
    localparam logic [CNT_W-1:0] VERTEX_COUNT_MAX = CNT_W'(MAX_VERTICES);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        REG_VERTEX_COUNT = 1'b0,
        REG_NONE         = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD_V,
        ST_NEXT,
        ST_TEST,
        ST_MUL,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
        logic [DIFF_W-1:0]   divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [PROD_W-1:0]   quotient;
    } div_stat_t;

endpackage

### hdl/point_in_polygon_crossing.sv
// Point-in-polygon test by crossing count, against a polygon held in a
// 64-entry vertex table.
// Input stream (s_*): one transaction per item. s_tuser selects the kind:
// load (0) writes point_x/point_y into slot vertex_index, query (1) tests
// the point against vertices 0 .. vertex_count-1. Load transactions produce
// nothing; each query produces one result transaction on m_* carrying
// inside_res (1 = inside).
// vertex_count sits at APB address 0 (reset value 3, saturated to 64).
// Write it only while the block is idle.
// A load is taken without leaving idle, so loads can follow back to back.
// In a query, an edge that passes the span check and is not vertical goes
// through multiply, divide and compare; other edges skip them. The 34-step
// restoring divider, shared by all edges, dominates a query, and s_tready
// stays low for the whole walk.
// Reset (synchronous, aresetn low) returns the sequencer to idle, drops any
// pending result and restores vertex_count; the vertex table is not cleared
// and a query must only touch slots loaded since reset.
// A stalled receiver holds the result in the output register; the block
// keeps taking loads and starts the next query, which then waits at its end
// until the previous result has been taken.
`include "assert_macros.svh"

module point_in_polygon_crossing
    import pip_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [5:0] vertex_index, [21:6] point_x, [37:22] point_y, [39:38] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] operation
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] inside_res, [7:1] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // unpack the input transaction
    logic [VIDX_W-1:0] in_idx;
    coord_t            in_x;
    coord_t            in_y;
    op_t               in_op;
    logic              in_acc;

    assign in_idx = s_tdata[VIDX_W-1:0];
    assign in_x   = s_tdata[VIDX_W +: COORD_BITS];
    assign in_y   = s_tdata[VIDX_W+COORD_BITS +: COORD_BITS];
    assign in_op  = op_t'(s_tuser[0]);
    assign in_acc = s_tvalid && s_tready;

    // configuration register
    logic [CNT_W-1:0] vcount_reg;
    reg_idx_t         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[2]);
    assign prdata  = (reg_sel == REG_VERTEX_COUNT) ? PDATA_W'(vcount_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VERTEX_COUNT_RST;
        end else if (psel && penable && pwrite && pready && reg_sel == REG_VERTEX_COUNT) begin
            vcount_reg <= pwdata[CNT_W-1:0];
        end
    end

    // sequencer and datapath registers
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  k_reg;
    logic              closing_reg;
    logic              parity_reg;
    logic              m_tvalid_reg;
    logic              inside_reg;
    coord_t            px_reg, py_reg;
    coord_t            ax_reg, ay_reg, bx_reg, by_reg;
    coord_t            prev_x_reg, prev_y_reg, first_x_reg, first_y_reg;
    logic signed [DIFF_W-1:0] dyp_reg, dx_reg, den_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic              neg_reg;

    // vertex table
    logic              ram_we;
    logic              ram_re;
    logic [VERT_W-1:0] ram_rdata;
    coord_t            rd_x, rd_y;

    assign ram_we = in_acc && in_op == OP_LOAD && int'(in_idx) < MAX_VERTICES;
    assign rd_x   = ram_rdata[COORD_BITS-1:0];
    assign rd_y   = ram_rdata[VERT_W-1:COORD_BITS];

    pip_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (IDX_W'(in_idx)),
        .wdata ({in_y, in_x}),
        .re    (ram_re),
        .raddr (k_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // shared divider
    div_ctrl_t div_ctrl;
    div_stat_t div_stat;
    logic      div_start;

    pip_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_stat)
    );

    // edge span test on the current edge
    coord_t lo_y, hi_y, hi_x;
    logic   in_span;
    logic   vertical;

    assign lo_y     = (ay_reg < by_reg) ? ay_reg : by_reg;
    assign hi_y     = (ay_reg > by_reg) ? ay_reg : by_reg;
    assign hi_x     = (ax_reg > bx_reg) ? ax_reg : bx_reg;
    assign in_span  = (py_reg > lo_y) && (py_reg <= hi_y) && (px_reg <= hi_x)
                      && (ay_reg != by_reg);
    assign vertical = ax_reg == bx_reg;

    // crossing x from the signed quotient
    logic signed [QUO_W:0] q_pos, q_s, cross_x, px_ext;

    assign q_pos   = $signed({1'b0, div_stat.quotient[QUO_W-1:0]});
    assign q_s     = neg_reg ? -q_pos : q_pos;
    assign cross_x = q_s + (QUO_W+1)'(ax_reg);
    assign px_ext  = (QUO_W+1)'(px_reg);

    // magnitudes into the divider
    assign div_ctrl = '{
        start:    div_start,
        dividend: prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg),
        divisor:  den_reg[DIFF_W-1] ? DIFF_W'(-den_reg) : DIFF_W'(den_reg)
    };

    logic n_zero;
    logic [CNT_W-1:0] n_sat;
    logic out_free;

    assign n_sat    = (vcount_reg > VERTEX_COUNT_MAX) ? VERTEX_COUNT_MAX : vcount_reg;
    assign n_zero   = n_sat == '0;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && in_op == OP_QUERY) begin
                    state_next = n_zero ? ST_DONE : ST_READ;
                end
            end
            ST_READ:    state_next = ST_LOAD_V;
            ST_LOAD_V:  state_next = (k_reg == '0) ? ST_NEXT : ST_TEST;
            ST_NEXT: begin
                priority if (closing_reg) begin
                    state_next = ST_DONE;
                end else if (k_reg == n_reg) begin
                    state_next = ST_TEST;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_TEST:    state_next = (in_span && !vertical) ? ST_MUL : ST_NEXT;
            ST_MUL:     state_next = ST_DIVGO;
            ST_DIVGO:   state_next = ST_DIVWAIT;
            ST_DIVWAIT: state_next = div_stat.done ? ST_CMP : ST_DIVWAIT;
            ST_CMP:     state_next = ST_NEXT;
            ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_re    = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_READ:  ram_re    = 1'b1;
            ST_DIVGO: div_start = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            n_reg        <= '0;
            k_reg        <= '0;
            closing_reg  <= 1'b0;
            parity_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // present a finished query, else drop a result once it is taken
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc && in_op == OP_QUERY) begin
                        n_reg       <= n_sat;
                        k_reg       <= '0;
                        closing_reg <= 1'b0;
                        parity_reg  <= 1'b0;
                    end
                end
                ST_LOAD_V: begin
                    k_reg <= k_reg + CNT_W'(1);
                end
                ST_NEXT: begin
                    // all vertices read: close the ring back to the first
                    if (!closing_reg && k_reg == n_reg) begin
                        closing_reg <= 1'b1;
                    end
                end
                ST_TEST: begin
                    if (in_span && vertical) begin
                        parity_reg <= !parity_reg;
                    end
                end
                ST_CMP: begin
                    if (px_ext <= cross_x) begin
                        parity_reg <= !parity_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_acc) begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (state_reg == ST_LOAD_V) begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
            if (k_reg == '0) begin
                first_x_reg <= rd_x;
                first_y_reg <= rd_y;
            end else begin
                ax_reg <= prev_x_reg;
                ay_reg <= prev_y_reg;
                bx_reg <= rd_x;
                by_reg <= rd_y;
            end
        end
        if (state_reg == ST_NEXT && !closing_reg && k_reg == n_reg) begin
            ax_reg <= prev_x_reg;
            ay_reg <= prev_y_reg;
            bx_reg <= first_x_reg;
            by_reg <= first_y_reg;
        end
        if (state_reg == ST_TEST) begin
            dyp_reg <= DIFF_W'(py_reg) - DIFF_W'(ay_reg);
            dx_reg  <= DIFF_W'(bx_reg) - DIFF_W'(ax_reg);
            den_reg <= DIFF_W'(by_reg) - DIFF_W'(ay_reg);
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= dyp_reg * dx_reg;
        end
        if (state_reg == ST_DIVGO) begin
            neg_reg <= prod_reg[PROD_W-1] ^ den_reg[DIFF_W-1];
        end
        if (state_reg == ST_DONE && out_free) begin
            inside_reg <= parity_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(inside_reg);

    `ASSERT_IMPLY(a_walk_bound, aclk, aresetn, 1'b1, k_reg <= n_reg, "vertex counter ran past the count")
    `ASSERT_IMPLY(a_div_idle_start, aclk, aresetn, div_ctrl.start, !div_stat.busy, "divider started while busy")
    `ASSERT_NEXT(a_done_delivers, aclk, aresetn, state_reg == ST_DONE && out_free, m_tvalid && state_reg == ST_IDLE, "finished query not presented")

endmodule

### hdl/pip_ram.sv
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/pip_div.sv
`include "assert_macros.svh"

module pip_div
    import pip_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  div_ctrl_t ctrl,
    output div_stat_t stat
);

    localparam int CNT_DW = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] dvd_reg, dvd_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [DIFF_W-1:0] dvs_reg, dvs_next;
    logic [DIFF_W-1:0] rem_reg, rem_next;
    logic [CNT_DW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIFF_W:0]   rem_sh;
    logic [DIFF_W:0]   rem_sub;
    logic              fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh  = {rem_reg, dvd_reg[PROD_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign fits    = rem_sh >= {1'b0, dvs_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start && !busy_reg) begin
            dvd_next  = ctrl.dividend;
            dvs_next  = ctrl.divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CNT_DW'(PROD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[PROD_W-2:0], 1'b0};
            quo_next = {quo_reg[PROD_W-2:0], fits};
            rem_next = fits ? rem_sub[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
            cnt_next = cnt_reg - CNT_DW'(1);
            if (cnt_reg == CNT_DW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

    `ASSERT_NEXT(a_start_sets_busy, aclk, aresetn, ctrl.start && !busy_reg, busy_reg, "divider did not start")
    `ASSERT_IMPLY(a_busy_has_count, aclk, aresetn, busy_reg, cnt_reg != '0, "divider busy with no steps left")

endmodule

### tb/point_in_polygon_crossing_checker.sv
module point_in_polygon_crossing_checker
    import pip_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [5:0] vertex_index, [21:6] point_x, [37:22] point_y, [39:38] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] operation
    input  logic [0:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] inside_res, [7:1] zero
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic                 pready,
    output int unsigned          mismatches,
    output int unsigned          awaiting,
    output int unsigned          results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int X_LSB = VIDX_W;
    localparam int Y_LSB = VIDX_W + COORD_BITS;
    localparam logic [PADDR_W-1:0] VERTEX_COUNT_ADDR = PADDR_W'(4 * int'(REG_VERTEX_COUNT));

    coord_t           poly_x [MAX_VERTICES];
    coord_t           poly_y [MAX_VERTICES];
    logic [CNT_W-1:0] vertices_in_use;
    bit               inside_due [$];
    int unsigned      fail_tally = 0;
    int unsigned      checked_tally = 0;

    // Crossing-number rule for one edge; exact arithmetic, division truncates.
    function automatic bit ray_crosses_edge(longint ax, longint ay, longint bx, longint by,
                                            longint px, longint py);
        longint lo_y;
        longint hi_y;
        longint hi_x;
        longint cross_x;
        lo_y = (ay < by) ? ay : by;
        hi_y = (ay > by) ? ay : by;
        hi_x = (ax > bx) ? ax : bx;
        if (!(py > lo_y) || !(py <= hi_y) || !(px <= hi_x) || ay == by)
            return 1'b0;
        if (ax == bx)
            return 1'b1;
        cross_x = (py - ay) * (bx - ax) / (by - ay) + ax;
        return px <= cross_x;
    endfunction

    function automatic bit point_is_inside(coord_t px, coord_t py);
        int unsigned n;
        int unsigned j;
        int unsigned crossings;
        n = (vertices_in_use > VERTEX_COUNT_MAX) ? MAX_VERTICES : vertices_in_use;
        crossings = 0;
        for (int unsigned i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            if (ray_crosses_edge(poly_x[i], poly_y[i], poly_x[j], poly_y[j], px, py))
                crossings++;
        end
        return crossings[0];
    endfunction

    always @(posedge aclk) begin
        op_t               op;
        logic [VIDX_W-1:0] slot;
        coord_t            px;
        coord_t            py;
        bit                want;
        if (!aresetn) begin
            vertices_in_use = VERTEX_COUNT_RST;
            inside_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == VERTEX_COUNT_ADDR)
                vertices_in_use = pwdata[CNT_W-1:0];
            if (s_tvalid && s_tready) begin
                op   = op_t'(s_tuser[0]);
                slot = s_tdata[VIDX_W-1:0];
                px   = s_tdata[X_LSB +: COORD_BITS];
                py   = s_tdata[Y_LSB +: COORD_BITS];
                if (op == OP_LOAD) begin
                    poly_x[slot] = px;
                    poly_y[slot] = py;
                end else begin
                    inside_due.push_back(point_is_inside(px, py));
                end
            end
            if (m_tvalid && m_tready) begin
                if (inside_due.size() == 0) begin
                    $error("result transaction with no query waiting: m_tdata=%h", m_tdata);
                    fail_tally++;
                end else begin
                    want = inside_due.pop_front();
                    checked_tally++;
                    if (m_tdata[0] !== want) begin
                        $error("inside_res mismatch: expected %0d, actual %b", want, m_tdata[0]);
                        fail_tally++;
                    end
                    if (m_tdata[M_TDATA_W-1:1] !== '0) begin
                        $error("m_tdata padding mismatch: expected 0, actual %h",
                               m_tdata[M_TDATA_W-1:1]);
                        fail_tally++;
                    end
                end
            end
        end
        mismatches      <= fail_tally;
        awaiting        <= inside_due.size();
        results_checked <= checked_tally;
    end

endmodule

### tb/point_in_polygon_crossing_tb.sv
module point_in_polygon_crossing_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pip_pkg::*;

    localparam int          RANDOM_ITEMS  = 270;
    // loads retire without leaving idle, so a short settle is enough before a register write
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_CYCLES   = 60;
    // generous ceiling: far beyond the slowest legal run of this stimulus
    localparam int unsigned TIMEOUT_NS    = 60_000_000;
    localparam int          COORD_LO      = -(2 ** (COORD_BITS - 1));
    localparam int          COORD_HI      = 2 ** (COORD_BITS - 1) - 1;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [5:0] vertex_index, [21:6] point_x, [37:22] point_y, [39:38] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // [0] operation
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [0] inside_res, [7:1] zero
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int unsigned mismatches;
    int unsigned awaiting;
    int unsigned results_checked;

    // Pacing knobs, in percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Stimulus bookkeeping: which slots hold a vertex, and what was put there
    bit          loaded  [MAX_VERTICES];
    coord_t      shape_x [MAX_VERTICES];
    coord_t      shape_y [MAX_VERTICES];
    int unsigned loads_sent   = 0;
    int unsigned queries_sent = 0;

    point_in_polygon_crossing dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    point_in_polygon_crossing_checker crossing_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: stall at random according to the current pacing phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop if the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // Offset a coordinate by up to +/- spread, clamped to the coordinate range
    function automatic int jitter(int centre, int spread);
        int v;
        v = centre + int'($urandom_range(2 * spread)) - spread;
        if (v < COORD_LO)
            v = COORD_LO;
        if (v > COORD_HI)
            v = COORD_HI;
        return v;
    endfunction

    // Offer one transaction on the input channel, with optional idle cycles in
    // front of it, and hold it until the block takes it
    task automatic push_item(op_t op, int unsigned slot, int x, int y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({coord_t'(y), coord_t'(x), VIDX_W'(slot)});
        do @(posedge aclk); while (!s_tready);
        if (op == OP_LOAD) begin
            loaded[slot]  = 1'b1;
            shape_x[slot] = coord_t'(x);
            shape_y[slot] = coord_t'(y);
            loads_sent++;
        end else begin
            queries_sent++;
        end
    endtask

    // Drop valid and wait until every query has returned its answer
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaiting != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Two-phase register write: setup, then access until pready
    task automatic apb_write(reg_idx_t idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int unsigned random_items;
        int unsigned seq_no;
        int unsigned n_req;
        int unsigned n_eff;
        int unsigned n_queries;
        int unsigned pick;
        int unsigned slot;
        int          spread;
        int          centre_x;
        int          centre_y;
        int          qx;
        int          qy;
        bit          full_range;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- Directed part ----
        // Vertex count is 3 out of reset: a triangle spanning the extremes
        push_item(OP_LOAD, 0, COORD_LO, COORD_LO);
        push_item(OP_LOAD, 1, COORD_HI, COORD_LO);
        push_item(OP_LOAD, 2, 0, COORD_HI);
        push_item(OP_QUERY, 63, 0, 0);
        push_item(OP_QUERY, 0, COORD_LO, COORD_LO);
        push_item(OP_QUERY, 21, COORD_HI, COORD_HI);
        push_item(OP_QUERY, 42, 0, COORD_HI);
        push_item(OP_QUERY, 5, COORD_HI, COORD_LO);
        push_item(OP_QUERY, 58, -1, COORD_LO + 1);

        // Triangle with a vertical edge: points on and just left of it
        push_item(OP_LOAD, 0, -100, -100);
        push_item(OP_LOAD, 1, -100, 100);
        push_item(OP_LOAD, 2, 200, 0);
        push_item(OP_QUERY, 0, -100, 0);
        push_item(OP_QUERY, 0, -101, 0);
        push_item(OP_QUERY, 0, 50, 100);
        push_item(OP_QUERY, 0, 50, 1);

        // Count of zero walks no edge, so the answer is outside
        drain_results();
        apb_write(REG_VERTEX_COUNT, 0);
        push_item(OP_QUERY, 0, 0, 0);

        // A single vertex gives one horizontal edge, which never counts
        drain_results();
        apb_write(REG_VERTEX_COUNT, 1);
        push_item(OP_QUERY, 0, -100, -100);

        // Two vertices: the edge walked there and back
        drain_results();
        apb_write(REG_VERTEX_COUNT, 2);
        push_item(OP_QUERY, 0, -100, 0);

        // Write to an unmapped address: the count must stay at two
        drain_results();
        apb_write(REG_NONE, 3);
        push_item(OP_QUERY, 0, 0, 50);

        // ---- Random part: a polygon per sequence, then queries against it ----
        random_items = 0;
        seq_no       = 0;
        while (random_items < RANDOM_ITEMS) begin
            // Advance through the pacing phases as the item budget is used up
            case (random_items * 4 / RANDOM_ITEMS)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 75;
                end
                default: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase

            // Mostly small polygons; a few full-table and saturating counts
            if (seq_no == 2) begin
                n_req = MAX_VERTICES;
            end else if (seq_no == 6) begin
                n_req = 2 ** CNT_W - 1;
            end else if (seq_no == 11) begin
                n_req = $urandom_range(2 ** CNT_W - 2, MAX_VERTICES + 1);
            end else begin
                pick = $urandom_range(99);
                if (pick < 4)
                    n_req = 0;
                else if (pick < 8)
                    n_req = 1;
                else if (pick < 12)
                    n_req = 2;
                else if (pick < 22)
                    n_req = $urandom_range(16, 9);
                else
                    n_req = $urandom_range(8, 3);
            end
            n_eff = (n_req > MAX_VERTICES) ? MAX_VERTICES : n_req;

            // Hold off until the block is idle before touching the register
            drain_results();
            apb_write(REG_VERTEX_COUNT, n_req);

            // Small spreads make shared coordinates, horizontal and vertical
            // edges and inexact crossing divisions common
            full_range = ($urandom_range(3) == 0);
            centre_x   = int'($urandom_range(64000)) - 32000;
            centre_y   = int'($urandom_range(64000)) - 32000;
            spread     = $urandom_range(1) ? int'($urandom_range(12, 4))
                                           : int'($urandom_range(400, 13));

            // Load every slot the walk will read; big tables reload only a few
            for (int s = 0; s < int'(n_eff); s++) begin
                if (!loaded[s] || n_eff <= 16 || $urandom_range(7) == 0) begin
                    if (full_range)
                        push_item(OP_LOAD, s, int'($urandom), int'($urandom));
                    else
                        push_item(OP_LOAD, s, jitter(centre_x, spread),
                                  jitter(centre_y, spread));
                    random_items++;
                end
            end

            // Noise: a stray load into a slot the current polygon does not use
            if (n_eff < MAX_VERTICES && $urandom_range(2) == 0) begin
                push_item(OP_LOAD, $urandom_range(MAX_VERTICES - 1, n_eff),
                          int'($urandom), int'($urandom));
                random_items++;
            end

            // Now and then let every answer come back mid-sequence
            if ($urandom_range(3) == 0)
                drain_results();

            n_queries = (n_eff > 16) ? 2 : $urandom_range(6, 2);
            for (int q = 0; q < int'(n_queries); q++) begin
                pick = $urandom_range(2);
                if (pick == 0 && n_eff > 0) begin
                    // On or next to a vertex
                    slot = $urandom_range(n_eff - 1);
                    qx   = jitter(shape_x[slot], $urandom_range(1));
                    qy   = jitter(shape_y[slot], $urandom_range(1));
                end else if (pick == 1 && !full_range) begin
                    qx = jitter(centre_x, spread + 2);
                    qy = jitter(centre_y, spread + 2);
                end else begin
                    qx = int'($urandom);
                    qy = int'($urandom);
                end
                push_item(OP_QUERY, $urandom_range(MAX_VERTICES - 1), qx, qy);
                random_items++;
            end
            seq_no++;
        end

        // ---- Wind down: collect the last answers, then watch a little longer ----
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d vertex loads and %0d point queries; %0d answers compared.",
                 loads_sent, queries_sent, results_checked);
        $display("Vertex counts went from 0 to 127 under idle, gappy and back-pressured pacing.");
        if (mismatches == 0 && awaiting == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/pip_pkg.sv
hdl/pip_ram.sv
hdl/pip_div.sv
hdl/point_in_polygon_crossing.sv
tb/point_in_polygon_crossing_checker.sv
tb/point_in_polygon_crossing_tb.sv
